FILE: rtl/sbus_rx_pkg.sv
// ----------------------------------------------------------------------------
// sbus_rx_pkg
// Types and constants shared by the SBUS frame receiver modules.
// ----------------------------------------------------------------------------
package sbus_rx_pkg;

  localparam logic [7:0] StartByte   = 8'h0F;
  localparam logic [7:0] EndByte     = 8'h00;
  localparam int unsigned ChannelBits = 11;
  localparam int unsigned MaxChannels = 16;
  localparam int unsigned DataBytes   = 22;
  localparam int unsigned DataBits    = DataBytes * 8;
  localparam logic [4:0] FlagsPos    = 5'd22;
  localparam logic [4:0] StoreDepth  = 5'd23;
  localparam logic [4:0] DigAIdx     = 5'd16;
  localparam logic [4:0] DigBIdx     = 5'd17;

  // flags byte bit positions
  localparam int unsigned FlagDigA     = 0;
  localparam int unsigned FlagDigB     = 1;
  localparam int unsigned FlagLost     = 4;
  localparam int unsigned FlagFailsafe = 5;

  localparam logic CmdByte = 1'b0;
  localparam logic CmdTick = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } sbus_in_t;

  typedef struct packed {
    logic [4:0]  channel_index;
    logic [10:0] channel_value;
    logic        frame_lost;
    logic        failsafe;
    logic        last;
  } sbus_out_t;

  typedef struct packed {
    logic data_we;
    logic flags_we;
    logic start;
  } sbus_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_RECV
  } sbus_state_e;

endpackage

FILE: rtl/sbus_rx_ctrl.sv
// ----------------------------------------------------------------------------
// sbus_rx_ctrl
// Frame sync: gap tick counter, start detection, byte counting, end check.
// ----------------------------------------------------------------------------
module sbus_rx_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_data_i,
  input  logic                 acc_i,
  input  sbus_rx_pkg::sbus_in_t item_i,
  output sbus_rx_pkg::sbus_ctl_t ctl_o
);
  import sbus_rx_pkg::*;

  sbus_state_e state_q, state_d;
  logic [7:0]  gap_q, gap_d;
  logic [7:0]  min_gap_q;
  logic [4:0]  count_q, count_d;
  logic        is_byte, is_tick;

  assign is_byte = acc_i && (item_i.cmd == CmdByte);
  assign is_tick = acc_i && (item_i.cmd == CmdTick);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (is_byte && (gap_q >= min_gap_q) && (item_i.rx_byte == StartByte)) begin
          state_d = ST_RECV;
        end
      end
      ST_RECV: begin
        if (is_byte && (count_q == StoreDepth)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    gap_d   = gap_q;
    count_d = count_q;
    ctl_o   = '0;
    if (is_tick && (gap_q != 8'hFF)) begin
      gap_d = gap_q + 8'd1;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (is_byte) begin
          gap_d   = '0;
          count_d = '0;
        end
      end
      ST_RECV: begin
        if (is_byte) begin
          if (count_q != StoreDepth) begin
            count_d        = count_q + 5'd1;
            ctl_o.data_we  = (count_q < FlagsPos);
            ctl_o.flags_we = (count_q == FlagsPos);
          end else begin
            count_d     = '0;
            gap_d       = '0;
            ctl_o.start = (item_i.rx_byte == EndByte);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      gap_q     <= '0;
      count_q   <= '0;
      min_gap_q <= 8'd6;
    end else begin
      state_q <= state_d;
      gap_q   <= gap_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        min_gap_q <= cfg_data_i;
      end
    end
  end

endmodule

FILE: rtl/sbus_rx_unpack.sv
// ----------------------------------------------------------------------------
// sbus_rx_unpack
// Byte-wide shift store for the channel bytes; emits one 11-bit channel digit
// per transfer from the bottom of the store, then the two digital channels.
// ----------------------------------------------------------------------------
module sbus_rx_unpack #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sbus_rx_pkg::sbus_ctl_t ctl_i,
  input  logic [7:0]             byte_i,
  output logic                   busy_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output sbus_rx_pkg::sbus_out_t out_data_o
);
  import sbus_rx_pkg::*;

  localparam logic [4:0] LastCh = 5'(CHANNELS - 1);

  logic [DataBits-1:0] sr_q, sr_d;
  logic [7:0]          flags_q;
  logic                busy_q, busy_d;
  logic [4:0]          idx_q, idx_d;
  logic                ovalid_q, ovalid_d;
  sbus_out_t           out_q, out_d;
  logic                emit;

  assign emit = busy_q && (!ovalid_q || !out_stall_i);

  always_comb begin
    sr_d     = sr_q;
    busy_d   = busy_q;
    idx_d    = idx_q;
    ovalid_d = ovalid_q && out_stall_i;
    out_d    = out_q;
    if (ctl_i.data_we) begin
      sr_d = {byte_i, sr_q[DataBits-1:8]};
    end
    if (ctl_i.start) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end
    if (emit) begin
      ovalid_d             = 1'b1;
      out_d.channel_index  = idx_q;
      out_d.frame_lost     = flags_q[FlagLost];
      out_d.failsafe       = flags_q[FlagFailsafe];
      out_d.last           = (idx_q == DigBIdx);
      if (idx_q == DigAIdx) begin
        out_d.channel_value = {10'd0, flags_q[FlagDigA]};
      end else if (idx_q == DigBIdx) begin
        out_d.channel_value = {10'd0, flags_q[FlagDigB]};
      end else begin
        out_d.channel_value = sr_q[ChannelBits-1:0];
        sr_d = {{ChannelBits{1'b0}}, sr_q[DataBits-1:ChannelBits]};
      end
      if (idx_q == DigBIdx) begin
        busy_d = 1'b0;
      end else if (idx_q == LastCh) begin
        idx_d = DigAIdx;
      end else begin
        idx_d = idx_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      busy_q   <= busy_d;
      ovalid_q <= ovalid_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q  <= sr_d;
    out_q <= out_d;
    if (ctl_i.flags_we) begin
      flags_q <= byte_i;
    end
  end

  assign busy_o      = busy_q;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/sbus_frame_receiver.sv
// ----------------------------------------------------------------------------
// sbus_frame_receiver
// SBUS frame decoder fed with received UART bytes and millisecond ticks.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries bytes (cmd 0) and ticks
// (cmd 1). A start byte 0x0F opens a frame once min_gap_ticks ticks have
// passed since the last idle byte or frame end; 23 bytes are stored and the
// 24th must be 0x00. A good frame yields CHANNELS+2 transfers on the output
// channel (out_valid_o / out_stall_i): channels 0..CHANNELS-1, then digital
// 16, 17, the last one flagged with last. A bad frame yields nothing.
// Other items leave the input free; the end byte of a good frame sets the
// unpacker's busy flag, and its results are then registered in the output
// register and follow one per cycle while the receiver does not stall, the
// unpacker producing one 11-bit channel per cycle from its shift store. The
// input channel stalls while that run is in progress.
// A receiver stall holds the current result in the output register and
// pauses the run. Reset returns to idle with a zero gap count and sets
// min_gap_ticks to 6; the configuration port is written via cfg_we_i.
// ----------------------------------------------------------------------------
module sbus_frame_receiver #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [7:0]              cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  sbus_rx_pkg::sbus_in_t   in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output sbus_rx_pkg::sbus_out_t  out_data_o
);
  import sbus_rx_pkg::*;

  sbus_ctl_t ctl;
  logic      busy;
  logic      acc;

  assign in_stall_o = busy;
  assign acc        = in_valid_i && !busy;

  sbus_rx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .acc_i      (acc),
    .item_i     (in_data_i),
    .ctl_o      (ctl)
  );

  sbus_rx_unpack #(
    .CHANNELS (CHANNELS)
  ) u_unpack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .byte_i      (in_data_i.rx_byte),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
